[src/sliding_window_avg_median_defines.svh]
// Assertion macros for the sliding window average and median block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_AVG_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_AVG_MEDIAN_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define SWAM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swam: same-cycle check failed");

// Next-cycle implication, ignored while in reset.
`define SWAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swam: next-cycle check failed");

`endif

[src/swam_pkg.sv]
// Shared constants, types and helpers for the sliding window average and median block.
// No dependencies.
package swam_pkg;

    localparam int WINDOW    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = $clog2(WINDOW);
    localparam int RANK_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = SAMPLE_W + IDX_W + 1;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

    typedef logic [SAMPLE_W-1:0]             sample_t;
    typedef logic [WINDOW-1:0][SAMPLE_W-1:0] window_t;

    typedef struct packed {
        logic             clear;
        logic             step;
        logic [IDX_W-1:0] idx;
    } rank_ctrl_t;

    typedef struct packed {
        logic start;
        logic floor_mode;
    } div_req_t;

    function automatic logic is_shift_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] nm1;
        begin
            nm1 = n - LEN_W'(1);
            return (n != LEN_W'(1)) && ((n & nm1) == '0);
        end
    endfunction

endpackage

[src/swam_window.sv]
// Sample store: shift line of the newest WINDOW samples, index 0 newest.
// Depends on swam_pkg.
module swam_window
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swam_pkg::sample_t sample,
    output swam_pkg::window_t window
);

    swam_pkg::window_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (push)
        begin
            win_reg <= {win_reg[swam_pkg::WINDOW-2:0], sample};
        end
    end

    assign window = win_reg;

endmodule

[src/swam_rank.sv]
// Rank lanes: one counter per window entry, one broadcast entry compared per cycle.
// Depends on swam_pkg.
module swam_rank
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  swam_pkg::rank_ctrl_t          ctrl,
    input  swam_pkg::window_t             window,
    input  logic [swam_pkg::LEN_W-1:0]    n,
    output swam_pkg::sample_t             entry,
    output swam_pkg::sample_t             median
);

    logic [swam_pkg::RANK_W-1:0] cnt_reg [swam_pkg::WINDOW];
    logic [swam_pkg::WINDOW-1:0] hit;
    logic [swam_pkg::LEN_W-1:0]  k;
    swam_pkg::sample_t           med_or;

    assign entry = window[ctrl.idx];
    assign k     = (n - swam_pkg::LEN_W'(1)) >> 1;

    for (genvar i = 0; i < swam_pkg::WINDOW; i++)
    begin : g_lane
        localparam logic [swam_pkg::IDX_W-1:0] LANE_IDX = swam_pkg::IDX_W'(i);
        localparam logic [swam_pkg::LEN_W-1:0] LANE_LEN = swam_pkg::LEN_W'(i);
        logic below;

        assign below = ($signed(entry) < $signed(window[i])) ||
                       ((entry == window[i]) && (ctrl.idx < LANE_IDX));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[i] <= '0;
            end
            else if (ctrl.clear)
            begin
                cnt_reg[i] <= '0;
            end
            else if (ctrl.step && below)
            begin
                cnt_reg[i] <= cnt_reg[i] + swam_pkg::RANK_W'(1);
            end
        end

        assign hit[i] = (LANE_LEN < n) &&
                        (swam_pkg::LEN_W'(cnt_reg[i]) == k);
    end

    always_comb
    begin
        med_or = '0;
        for (int i = 0; i < swam_pkg::WINDOW; i++)
        begin
            med_or = med_or | (window[i] & {swam_pkg::SAMPLE_W{hit[i]}});
        end
    end

    assign median = med_or;

endmodule

[src/swam_div.sv]
// Restoring divider, one quotient bit per cycle; signed sum by window length.
// Floors for shift lengths, truncates toward zero otherwise. Depends on swam_pkg.
module swam_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  swam_pkg::div_req_t                  req,
    input  logic signed [swam_pkg::SUM_W-1:0]   dividend,
    input  logic [swam_pkg::LEN_W-1:0]          divisor,
    output logic                                done,
    output swam_pkg::sample_t                   quotient
);

    localparam logic [swam_pkg::DCNT_W-1:0] LAST_STEP =
        swam_pkg::DCNT_W'(swam_pkg::DIV_STEPS - 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [swam_pkg::DCNT_W-1:0]       cnt_reg;
    logic [swam_pkg::MAG_W-1:0]        mag_reg;
    logic [swam_pkg::LEN_W-1:0]        rem_reg;
    logic [swam_pkg::LEN_W-1:0]        div_reg;
    logic                              neg_reg;
    logic                              floor_reg;

    logic [swam_pkg::SUM_W-1:0]        abs_val;
    logic [swam_pkg::LEN_W:0]          trial;
    logic                              qbit;
    logic [swam_pkg::LEN_W-1:0]        rem_next;
    logic [swam_pkg::SAMPLE_W:0]       qmag;
    logic [swam_pkg::SAMPLE_W:0]       qsgn;

    assign abs_val  = dividend[swam_pkg::SUM_W-1] ? -dividend : dividend;
    assign trial    = {rem_reg, mag_reg[swam_pkg::MAG_W-1]};
    assign qbit     = (trial >= {1'b0, div_reg});
    assign rem_next = qbit ? swam_pkg::LEN_W'(trial - {1'b0, div_reg})
                           : trial[swam_pkg::LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            mag_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            neg_reg   <= 1'b0;
            floor_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                mag_reg   <= abs_val[swam_pkg::MAG_W-1:0];
                rem_reg   <= '0;
                div_reg   <= divisor;
                neg_reg   <= dividend[swam_pkg::SUM_W-1];
                floor_reg <= req.floor_mode;
            end
            else if (busy_reg)
            begin
                mag_reg <= {mag_reg[swam_pkg::MAG_W-2:0], qbit};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + swam_pkg::DCNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        qmag = {1'b0, mag_reg[swam_pkg::SAMPLE_W-1:0]};
        qsgn = neg_reg ? -qmag : qmag;
        if (floor_reg && neg_reg && (rem_reg != '0))
        begin
            qsgn = qsgn - (swam_pkg::SAMPLE_W + 1)'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = qsgn[swam_pkg::SAMPLE_W-1:0];

endmodule

[src/sliding_window_avg_median.sv]
// Sliding window average and median, top level. Depends on swam_pkg, swam_window,
// swam_rank, swam_div and sliding_window_avg_median_defines.svh.
// A new beat is taken only when idle: each beat runs the rank scan (one entry a cycle), then
// the 21-step divider, and may wait for the output register before the next is taken.
// Reset clears the store to zeros, sets length 32.
`include "sliding_window_avg_median_defines.svh"

module sliding_window_avg_median
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swam_pkg::LEN_W-1:0]    cfg_wdata,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [15:0]            sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [15:0]            average,
    output logic signed [15:0]            median
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                              state_reg;
    logic [swam_pkg::LEN_W-1:0]          len_reg;
    logic [swam_pkg::LEN_W-1:0]          n_reg;
    logic [swam_pkg::IDX_W-1:0]          scan_idx_reg;
    logic signed [swam_pkg::SUM_W-1:0]   sum_reg;
    logic                                result_valid_reg;
    swam_pkg::sample_t                   average_reg;
    swam_pkg::sample_t                   median_reg;

    logic [swam_pkg::LEN_W-1:0]          n_next;
    logic                                scan_last;
    logic                                accept;
    swam_pkg::window_t                   window;
    swam_pkg::rank_ctrl_t                rank_ctrl;
    swam_pkg::div_req_t                  div_req;
    swam_pkg::sample_t                   entry;
    swam_pkg::sample_t                   med_sel;
    swam_pkg::sample_t                   quotient;
    logic                                div_done;

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign scan_last    = (swam_pkg::LEN_W'(scan_idx_reg) == (n_reg - swam_pkg::LEN_W'(1)));

    always_comb
    begin
        priority if (len_reg == '0)
        begin
            n_next = swam_pkg::LEN_W'(1);
        end
        else if (len_reg > swam_pkg::LEN_W'(swam_pkg::WINDOW))
        begin
            n_next = swam_pkg::LEN_W'(swam_pkg::WINDOW);
        end
        else
        begin
            n_next = len_reg;
        end
    end

    always_comb
    begin
        rank_ctrl.clear    = accept;
        rank_ctrl.step     = (state_reg == ST_SCAN);
        rank_ctrl.idx      = scan_idx_reg;
        div_req.start      = (state_reg == ST_START);
        div_req.floor_mode = swam_pkg::is_shift_len(n_reg);
    end

    swam_window u_window
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .sample (sample),
        .window (window)
    );

    swam_rank u_rank
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (rank_ctrl),
        .window (window),
        .n      (n_reg),
        .entry  (entry),
        .median (med_sel)
    );

    swam_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            len_reg          <= swam_pkg::LEN_RESET;
            n_reg            <= swam_pkg::LEN_W'(1);
            scan_idx_reg     <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
            average_reg      <= '0;
            median_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (result_valid_reg && result_ready && (state_reg != ST_DONE))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        n_reg        <= n_next;
                        scan_idx_reg <= '0;
                        sum_reg      <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    sum_reg      <= sum_reg + swam_pkg::SUM_W'($signed(entry));
                    scan_idx_reg <= scan_idx_reg + swam_pkg::IDX_W'(1);
                    if (scan_last)
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (!result_valid_reg || result_ready)
                    begin
                        average_reg      <= quotient;
                        median_reg       <= med_sel;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign average      = average_reg;
    assign median       = median_reg;

    `SWAM_ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `SWAM_ASSERT_NEXT(a_accept_starts_scan, accept, (state_reg == ST_SCAN) && (scan_idx_reg == '0))
    `SWAM_ASSERT_IMPL(a_scan_in_window, state_reg == ST_SCAN, swam_pkg::LEN_W'(scan_idx_reg) < n_reg)

endmodule

[bench/sliding_window_avg_median_tb.sv]
// Self-checking bench for sliding_window_avg_median: directed probes, then random phases
// at random window lengths, against an in-bench mean and lower-median model.
// Depends on swam_pkg and the sliding_window_avg_median top level.
`timescale 1ns / 1ps

module sliding_window_avg_median_tb;

    localparam int KEEP_LEN     = -1;
    localparam int RANDOM_ITEMS = 1400;
    localparam int MAX_GAP      = 5;
    localparam int DRAIN_CYCLES = swam_pkg::WINDOW + 40;

    typedef struct packed {
        logic signed [15:0] average;
        logic signed [15:0] median;
    } window_stats_t;

    typedef struct packed {
        int                 new_len;
        logic signed [15:0] value;
        bit                 typed;
        logic signed [15:0] avg;
        logic signed [15:0] med;
    } probe_row_t;

    localparam int PROBE_COUNT = 23;

    probe_row_t probes [PROBE_COUNT] = '{
        '{KEEP_LEN, 16'sh7FFF,    1'b0, 16'sh0,     16'sh0},
        '{KEEP_LEN, 16'sh8000,    1'b0, 16'sh0,     16'sh0},
        '{KEEP_LEN, 16'sh0000,    1'b0, 16'sh0,     16'sh0},
        '{1,        16'sh8000,    1'b1, 16'sh8000,  16'sh8000},
        '{KEEP_LEN, 16'sh7FFF,    1'b1, 16'sh7FFF,  16'sh7FFF},
        '{0,        16'sd12345,   1'b1, 16'sd12345, 16'sd12345},
        '{0,        -16'sd1,      1'b1, -16'sd1,    -16'sd1},
        '{2,        -16'sd1,      1'b0, 16'sh0,     16'sh0},
        '{KEEP_LEN, -16'sd2,      1'b0, 16'sh0,     16'sh0},
        '{3,        -16'sd1,      1'b0, 16'sh0,     16'sh0},
        '{KEEP_LEN, -16'sd1,      1'b0, 16'sh0,     16'sh0},
        '{KEEP_LEN, 16'sd1,       1'b0, 16'sh0,     16'sh0},
        '{5,        16'sd100,     1'b0, 16'sh0,     16'sh0},
        '{63,       16'sh8000,    1'b0, 16'sh0,     16'sh0},
        '{KEEP_LEN, 16'sh8000,    1'b0, 16'sh0,     16'sh0},
        '{33,       16'sh7FFF,    1'b0, 16'sh0,     16'sh0},
        '{31,       16'sd1,       1'b0, 16'sh0,     16'sh0},
        '{32,       -16'sd3,      1'b0, 16'sh0,     16'sh0},
        '{6,        16'sd7,       1'b0, 16'sh0,     16'sh0},
        '{4,        -16'sd32767,  1'b0, 16'sh0,     16'sh0},
        '{16,       16'sh5555,    1'b0, 16'sh0,     16'sh0},
        '{8,        -16'sd5,      1'b0, 16'sh0,     16'sh0},
        '{7,        16'shAAAA,    1'b0, 16'sh0,     16'sh0}
    };

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [swam_pkg::LEN_W-1:0] cfg_wdata    = '0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic signed [15:0]         sample       = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic signed [15:0]         average;
    logic signed [15:0]         median;

    logic signed [15:0]         history [swam_pkg::WINDOW];
    logic [swam_pkg::LEN_W-1:0] win_len;
    window_stats_t              pending_stats [$];
    bit                         gaps_on = 1'b1;
    int                         mismatches = 0;

    sliding_window_avg_median dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average      (average),
        .median       (median)
    );

    always #10 clk = ~clk;

    function automatic window_stats_t slide_and_measure(input logic signed [15:0] s);
        int                 n;
        int                 total;
        int                 q;
        int                 i;
        int                 j;
        logic signed [15:0] sorted [swam_pkg::WINDOW];
        logic signed [15:0] v;
        window_stats_t      r;
        for (i = swam_pkg::WINDOW - 1; i > 0; i--)
        begin
            history[i] = history[i - 1];
        end
        history[0] = s;
        if (win_len == 0)
            n = 1;
        else if (int'(win_len) > swam_pkg::WINDOW)
            n = swam_pkg::WINDOW;
        else
            n = int'(win_len);
        total = 0;
        for (i = 0; i < n; i++)
        begin
            total += int'(history[i]);
        end
        q = total / n;
        if ((n == 2 || n == 4 || n == 8 || n == 16 || n == 32) && total < 0 && total % n != 0)
            q--;
        for (i = 0; i < n; i++)
        begin
            v = history[i];
            j = i;
            while (j > 0 && sorted[j - 1] > v)
            begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
        end
        r.average = 16'(q);
        r.median  = sorted[(n - 1) / 2];
        return r;
    endfunction

    task automatic set_window_len(input logic [swam_pkg::LEN_W-1:0] len);
        sample_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we  <= 1'b0;
        win_len = len;
    endtask

    task automatic push_sample(input logic signed [15:0] value, input bit typed,
                               input window_stats_t typed_stats);
        int            gap;
        window_stats_t predicted;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        do @(posedge clk); while (!sample_ready);
        predicted = slide_and_measure(value);
        pending_stats.push_back(typed ? typed_stats : predicted);
    endtask

    function automatic logic signed [15:0] draw_sample(input logic signed [15:0] last);
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            3: return last;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [swam_pkg::LEN_W-1:0] draw_len();
        case ($urandom_range(0, 7))
            0: return swam_pkg::LEN_W'(0);
            1: return swam_pkg::LEN_W'(1);
            2: return swam_pkg::LEN_W'(2);
            3: return swam_pkg::LEN_W'(32);
            4: return swam_pkg::LEN_W'(33);
            5: return swam_pkg::LEN_W'(63);
            default: return swam_pkg::LEN_W'($urandom_range(0, 63));
        endcase
    endfunction

    initial
    begin
        int                 k;
        int                 sent;
        int                 burst;
        logic signed [15:0] last;
        for (k = 0; k < swam_pkg::WINDOW; k++)
        begin
            history[k] = '0;
        end
        win_len = swam_pkg::LEN_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < PROBE_COUNT; k++)
        begin
            if (probes[k].new_len != KEEP_LEN)
                set_window_len(swam_pkg::LEN_W'(probes[k].new_len));
            push_sample(probes[k].value, probes[k].typed, '{probes[k].avg, probes[k].med});
        end

        sent = 0;
        last = '0;
        while (sent < RANDOM_ITEMS)
        begin
            set_window_len(draw_len());
            gaps_on = ($urandom_range(0, 3) != 0);
            burst   = $urandom_range(10, 60);
            repeat (burst)
            begin
                last = draw_sample(last);
                push_sample(last, 1'b0, '0);
                sent++;
            end
        end
        sample_valid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("sliding_window_avg_median_tb: clean");
        else
            $display("sliding_window_avg_median_tb: errors");
        $finish;
    end

    initial
    begin
        int            stall;
        window_stats_t want;
        forever
        begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            if (pending_stats.size() == 0)
            begin
                $error("unexpected beat: average %0d, median %0d", average, median);
                mismatches++;
            end
            else
            begin
                want = pending_stats.pop_front();
                if (average !== want.average)
                begin
                    $error("average: expected %0d, got %0d", want.average, average);
                    mismatches++;
                end
                if (median !== want.median)
                begin
                    $error("median: expected %0d, got %0d", want.median, median);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("sliding_window_avg_median_tb: errors");
        $finish;
    end

endmodule
